### hdl/tbil_pkg.sv
// Shared constants for the bilinear table lookup: sizes, field layout and codes.
package tbil_pkg;

   localparam int SPECIES   = 4;
   localparam int TA_POINTS = 64;
   localparam int U_POINTS  = 64;

   localparam int SPEC_AW = (SPECIES > 1) ? $clog2(SPECIES) : 1;
   localparam int ROW_W   = $clog2(TA_POINTS);
   localparam int COL_W   = $clog2(U_POINTS);
   localparam int HROW_W  = (TA_POINTS > 2) ? $clog2((TA_POINTS + 1) / 2) : 1;
   localparam int HCOL_W  = (U_POINTS > 2) ? $clog2((U_POINTS + 1) / 2) : 1;
   localparam int BANK_AW = SPEC_AW + HROW_W + HCOL_W;
   localparam int BANK_DEPTH = 1 << BANK_AW;

   localparam int XW = ROW_W + 16;
   localparam int YW = COL_W + 16;
   localparam logic [31:0] XCAP = 32'(TA_POINTS - 1) << 16;
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   localparam logic CSR_GRID_START    = 1'b0;
   localparam logic CSR_GRID_INV_STEP = 1'b1;
   localparam logic [23:0] GRID_START_RESET    = 24'd0;
   localparam logic [23:0] GRID_INV_STEP_RESET = 24'd65536;

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 16;

   localparam int F_SPECIES_LO = 0;
   localparam int F_ROW_LO     = 2;
   localparam int F_COL_LO     = 8;
   localparam int F_ENTRY_LO   = 14;
   localparam int F_LOG_LO     = 30;
   localparam int F_INVALID    = 54;
   localparam int F_U_LO       = 55;

endpackage

### hdl/table_bilinear_interp_lookup.sv
// Pipelined bilinear lookup over four parity-banked deflection tables.
// A lookup word moves through each stage register and leaves from the output register.
// Throughput: one word per cycle unless rsp stalls; each bank is read once per word.
// The whole pipeline advances together and holds while a result waits on rsp.
// Reset clears the pipeline valid bits and write enables and sets the two grid registers
// to their defaults; the table is not cleared and holds no defined value until written.
module table_bilinear_interp_lookup (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // species, row_index, column_index, entry_value, log_ta_value,
   // log_ta_invalid, u_fraction, zero fill
   input  logic [tbil_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // kind
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // chi_value
   output logic [tbil_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [23:0]                       csr_wdata
);
   import tbil_pkg::*;

   logic adv;

   logic signed [23:0] grid_start_ff;
   logic [23:0]        grid_inv_step_ff;

   logic [1:0]         f_species;
   logic [5:0]         f_row;
   logic [5:0]         f_col;
   logic [15:0]        f_entry;
   logic signed [23:0] f_log;
   logic               f_invalid;
   logic signed [17:0] f_u;

   logic               spec_ok;
   logic signed [24:0] d_in;
   logic [16:0]        u_in;

   logic               s1_valid_ff, s1_kind_ff, s1_zero_ff, s1_wok_ff;
   logic [SPEC_AW-1:0] s1_spec_ff;
   logic [ROW_W-1:0]   s1_wrow_ff;
   logic [COL_W-1:0]   s1_wcol_ff;
   logic [15:0]        s1_wdata_ff;
   logic signed [24:0] s1_d_ff;
   logic [16:0]        s1_u_ff;

   logic [23:0]        dpos;
   logic [47:0]        xprod;
   logic [YW-1:0]      y_in;

   logic               s2_valid_ff, s2_kind_ff, s2_zero_ff, s2_wok_ff;
   logic [SPEC_AW-1:0] s2_spec_ff;
   logic [ROW_W-1:0]   s2_wrow_ff;
   logic [COL_W-1:0]   s2_wcol_ff;
   logic [15:0]        s2_wdata_ff;
   logic [31:0]        s2_x_ff;
   logic [YW-1:0]      s2_y_ff;

   logic [XW-1:0]      x;
   logic [ROW_W-1:0]   i0;
   logic [COL_W-1:0]   j0;
   logic [HROW_W-1:0]  hrow_even, hrow_odd, hrow_w;
   logic [HCOL_W-1:0]  hcol_even, hcol_odd, hcol_w;
   logic [BANK_AW-1:0] addr_in [4];
   logic [3:0]         we_in;

   logic               s3_valid_ff, s3_kind_ff, s3_zero_ff;
   logic [BANK_AW-1:0] s3_addr_ff [4];
   logic [3:0]         s3_we_ff;
   logic [15:0]        s3_wdata_ff;
   logic [15:0]        s3_fx_ff, s3_fy_ff;
   logic               s3_ip_ff, s3_jp_ff, s3_iedge_ff, s3_jedge_ff;

   logic [15:0]        s4_rd_ff [4];
   logic               s4_valid_ff, s4_kind_ff, s4_zero_ff;
   logic [15:0]        s4_fx_ff, s4_fy_ff;
   logic               s4_ip_ff, s4_jp_ff, s4_iedge_ff, s4_jedge_ff;

   logic [15:0]        c00, c10, c01, c11;
   logic signed [16:0] dx0, dx1;
   logic signed [33:0] px0, px1;
   logic signed [33:0] c0_in, c1_in;

   logic               s5_valid_ff, s5_kind_ff, s5_zero_ff;
   logic [15:0]        s5_fy_ff;
   logic [31:0]        s5_c0_ff, s5_c1_ff;

   logic signed [32:0] dy;
   logic signed [49:0] py_in;

   logic               s6_valid_ff, s6_kind_ff, s6_zero_ff;
   logic [31:0]        s6_c0_ff;
   logic signed [49:0] s6_py_ff;

   logic signed [50:0] r_sum;
   logic [15:0]        chi_in;
   logic               rsp_tvalid_ff;
   logic [15:0]        rsp_tdata_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_start_ff    <= GRID_START_RESET;
         grid_inv_step_ff <= GRID_INV_STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_START:    grid_start_ff    <= csr_wdata;
            CSR_GRID_INV_STEP: grid_inv_step_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: unpack, offset the row coordinate and clamp u into 0..1.0.
   assign f_species = req_tdata[F_SPECIES_LO +: 2];
   assign f_row     = req_tdata[F_ROW_LO +: 6];
   assign f_col     = req_tdata[F_COL_LO +: 6];
   assign f_entry   = req_tdata[F_ENTRY_LO +: 16];
   assign f_log     = req_tdata[F_LOG_LO +: 24];
   assign f_invalid = req_tdata[F_INVALID];
   assign f_u       = req_tdata[F_U_LO +: 18];

   assign spec_ok = 32'(f_species) < SPECIES;
   assign d_in    = 25'(f_log) - 25'(grid_start_ff);

   always_comb begin
      if (f_u[17]) begin
         u_in = '0;
      end else if (f_u[16:0] > ONE_Q16) begin
         u_in = ONE_Q16;
      end else begin
         u_in = f_u[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff  <= req_tuser;
         s1_zero_ff  <= f_invalid || !spec_ok;
         s1_wok_ff   <= spec_ok && (32'(f_row) < TA_POINTS) && (32'(f_col) < U_POINTS);
         s1_spec_ff  <= SPEC_AW'(f_species);
         s1_wrow_ff  <= ROW_W'(f_row);
         s1_wcol_ff  <= COL_W'(f_col);
         s1_wdata_ff <= f_entry;
         s1_d_ff     <= d_in;
         s1_u_ff     <= u_in;
      end
   end

   // Stage 2: floor the row offset at zero, scale it by the inverse step and u by U_POINTS - 1.
   assign dpos  = (s1_d_ff > 25'sd0) ? s1_d_ff[23:0] : 24'd0;
   assign xprod = 48'(dpos) * 48'(grid_inv_step_ff);
   assign y_in  = YW'(s1_u_ff) * YW'(U_POINTS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_kind_ff  <= s1_kind_ff;
         s2_zero_ff  <= s1_zero_ff;
         s2_wok_ff   <= s1_wok_ff;
         s2_spec_ff  <= s1_spec_ff;
         s2_wrow_ff  <= s1_wrow_ff;
         s2_wcol_ff  <= s1_wcol_ff;
         s2_wdata_ff <= s1_wdata_ff;
         s2_x_ff     <= xprod[47:16];
         s2_y_ff     <= y_in;
      end
   end

   // Stage 3: cap the row coordinate and form one address per parity bank.
   // Bank index is {row parity, column parity}.
   assign x  = (s2_x_ff > XCAP) ? XW'(XCAP) : XW'(s2_x_ff);
   assign i0 = x[XW-1:16];
   assign j0 = s2_y_ff[YW-1:16];

   assign hrow_odd  = HROW_W'(i0 >> 1);
   assign hrow_even = HROW_W'(i0 >> 1) + HROW_W'(i0[0]);
   assign hcol_odd  = HCOL_W'(j0 >> 1);
   assign hcol_even = HCOL_W'(j0 >> 1) + HCOL_W'(j0[0]);
   assign hrow_w    = HROW_W'(s2_wrow_ff >> 1);
   assign hcol_w    = HCOL_W'(s2_wcol_ff >> 1);

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         if (s2_kind_ff == KIND_WRITE) begin
            addr_in[b] = {s2_spec_ff, hrow_w, hcol_w};
            we_in[b]   = s2_valid_ff && s2_wok_ff && ({s2_wrow_ff[0], s2_wcol_ff[0]} == 2'(b));
         end else begin
            addr_in[b] = {s2_spec_ff, (b >= 2) ? hrow_odd : hrow_even,
                          (b % 2 == 1) ? hcol_odd : hcol_even};
            we_in[b]   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s3_we_ff    <= '0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
         s3_we_ff    <= we_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_kind_ff  <= s2_kind_ff;
         s3_zero_ff  <= s2_zero_ff;
         s3_addr_ff  <= addr_in;
         s3_wdata_ff <= s2_wdata_ff;
         s3_fx_ff    <= x[15:0];
         s3_fy_ff    <= s2_y_ff[15:0];
         s3_ip_ff    <= i0[0];
         s3_jp_ff    <= j0[0];
         s3_iedge_ff <= 32'(i0) == TA_POINTS - 1;
         s3_jedge_ff <= 32'(j0) == U_POINTS - 1;
      end
   end

   // Stage 4: table banks. Writes and reads both happen here, in item order.
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [15:0] mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (adv) begin
            if (s3_we_ff[b]) begin
               mem[s3_addr_ff[b]] <= s3_wdata_ff;
            end
            s4_rd_ff[b] <= mem[s3_addr_ff[b]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_kind_ff  <= s3_kind_ff;
         s4_zero_ff  <= s3_zero_ff;
         s4_fx_ff    <= s3_fx_ff;
         s4_fy_ff    <= s3_fy_ff;
         s4_ip_ff    <= s3_ip_ff;
         s4_jp_ff    <= s3_jp_ff;
         s4_iedge_ff <= s3_iedge_ff;
         s4_jedge_ff <= s3_jedge_ff;
      end
   end

   // Stage 5: steer the banks onto the four neighbors and blend along rows.
   // At the last row or column the neighbor repeats its partner, whose weight is zero.
   always_comb begin
      c00 = s4_rd_ff[{s4_ip_ff, s4_jp_ff}];
      c10 = s4_iedge_ff ? c00 : s4_rd_ff[{!s4_ip_ff, s4_jp_ff}];
      c01 = s4_jedge_ff ? c00 : s4_rd_ff[{s4_ip_ff, !s4_jp_ff}];
      if (s4_iedge_ff) begin
         c11 = c01;
      end else if (s4_jedge_ff) begin
         c11 = c10;
      end else begin
         c11 = s4_rd_ff[{!s4_ip_ff, !s4_jp_ff}];
      end
   end

   assign dx0   = signed'({1'b0, c10}) - signed'({1'b0, c00});
   assign dx1   = signed'({1'b0, c11}) - signed'({1'b0, c01});
   assign px0   = 34'(dx0) * 34'(signed'({1'b0, s4_fx_ff}));
   assign px1   = 34'(dx1) * 34'(signed'({1'b0, s4_fx_ff}));
   assign c0_in = signed'({2'b00, c00, 16'h0000}) + px0;
   assign c1_in = signed'({2'b00, c01, 16'h0000}) + px1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_kind_ff <= s4_kind_ff;
         s5_zero_ff <= s4_zero_ff;
         s5_fy_ff   <= s4_fy_ff;
         s5_c0_ff   <= c0_in[31:0];
         s5_c1_ff   <= c1_in[31:0];
      end
   end

   // Stage 6: column blend product.
   assign dy    = signed'({1'b0, s5_c1_ff}) - signed'({1'b0, s5_c0_ff});
   assign py_in = 50'(dy) * 50'(signed'({1'b0, s5_fy_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_kind_ff <= s5_kind_ff;
         s6_zero_ff <= s5_zero_ff;
         s6_c0_ff   <= s5_c0_ff;
         s6_py_ff   <= py_in;
      end
   end

   // Stage 7: final sum, round to nearest with ties up, and output register.
   assign r_sum  = signed'({3'b000, s6_c0_ff, 16'h0000}) + 51'(s6_py_ff)
                   + 51'sh0_0000_8000_0000;
   assign chi_in = s6_zero_ff ? 16'd0 : r_sum[47:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= s6_valid_ff && (s6_kind_ff == KIND_LOOKUP);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= chi_in;
      end
   end

endmodule

### tb/sv/tb_table_bilinear_interp_lookup.sv
// Self-checking testbench for the bilinear table lookup: table writes, lookups and grid settings.
module tb_table_bilinear_interp_lookup;
   import tbil_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int          DRAIN_CYCLES = 12;
   localparam int          STORE_SIZE = SPECIES * TA_POINTS * U_POINTS;

   class chi_scoreboard;
      bit [15:0]   entry_copy [STORE_SIZE];
      bit          chi_written [STORE_SIZE];
      logic [23:0] grid_start;
      logic [23:0] grid_inv_step;
      bit [15:0]   pending_chi [$];
      int unsigned mismatches;

      function new();
         grid_start = GRID_START_RESET;
         grid_inv_step = GRID_INV_STEP_RESET;
         mismatches = 0;
      endfunction

      function int slot(int s, int r, int c);
         return (s * TA_POINTS + r) * U_POINTS + c;
      endfunction

      // Maps a lookup to its four neighbors and the two Q.16 blend fractions.
      function void locate(input logic [23:0] log_ta, input logic [17:0] u,
                           output int i0, output int i1, output int j0, output int j1,
                           output longint fx, output longint fy);
         longint d, x, uq, y, xcap, ycap;
         xcap = longint'(TA_POINTS - 1) << 16;
         ycap = longint'(U_POINTS - 1) << 16;
         d = longint'($signed(log_ta)) - longint'($signed(grid_start));
         x = 0;
         if (d > 0) begin
            x = (d * longint'(grid_inv_step)) >>> 16;
            if (x > xcap) x = xcap;
         end
         i0 = int'(x >>> 16);
         i1 = (i0 + 1 < TA_POINTS) ? i0 + 1 : TA_POINTS - 1;
         fx = x & 64'hFFFF;
         uq = longint'($signed(u));
         if (uq < 0) uq = 0;
         if (uq > 65536) uq = 65536;
         y = uq * (U_POINTS - 1);
         if (y > ycap) y = ycap;
         j0 = int'(y >>> 16);
         j1 = (j0 + 1 < U_POINTS) ? j0 + 1 : U_POINTS - 1;
         fy = y & 64'hFFFF;
      endfunction

      function void note_word(bit kind, logic [REQ_TDATA_W-1:0] w);
         logic [SPEC_AW-1:0] s;
         int i0, i1, j0, j1;
         longint fx, fy, c00, c10, c01, c11, c0, c1, r, v;
         s = w[F_SPECIES_LO +: SPEC_AW];
         if (kind == KIND_WRITE) begin
            entry_copy[slot(s, w[F_ROW_LO +: ROW_W], w[F_COL_LO +: COL_W])] = w[F_ENTRY_LO +: 16];
            chi_written[slot(s, w[F_ROW_LO +: ROW_W], w[F_COL_LO +: COL_W])] = 1'b1;
         end else if (w[F_INVALID]) begin
            pending_chi.push_back(16'd0);
         end else begin
            locate(w[F_LOG_LO +: 24], w[F_U_LO +: 18], i0, i1, j0, j1, fx, fy);
            c00 = entry_copy[slot(s, i0, j0)];
            c10 = entry_copy[slot(s, i1, j0)];
            c01 = entry_copy[slot(s, i0, j1)];
            c11 = entry_copy[slot(s, i1, j1)];
            c0 = (65536 - fx) * c00 + fx * c10;
            c1 = (65536 - fx) * c01 + fx * c11;
            r = (65536 - fy) * c0 + fy * c1;
            v = (r + (longint'(1) << 31)) >>> 32;
            if (v > 65535) v = 65535;
            pending_chi.push_back(16'(v));
         end
      endfunction

      function void check_chi(bit [15:0] got);
         bit [15:0] want;
         if (pending_chi.size() == 0) begin
            $display("%0t: chi_value expected none, got %h", $time, got);
            mismatches++;
         end else begin
            want = pending_chi.pop_front();
            if (want != got) begin
               $display("%0t: chi_value expected %h, got %h", $time, want, got);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic                   csr_index = 1'b0;
   logic [23:0]            csr_wdata = '0;

   chi_scoreboard sb = new();
   int unsigned   cycle_count = 0;
   int            words_sent = 0;
   int            stall_left = 0;
   bit            req_gaps_on = 1'b0;
   bit            rsp_stalls_on = 1'b0;

   table_bilinear_interp_lookup dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("table_bilinear_interp_lookup regression: fail");
         $finish;
      end
   end

   function automatic int gap_cycles();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_chi(rsp_tdata);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 99) < 20) begin
         stall_left = gap_cycles() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [REQ_TDATA_W-1:0] pack_req(logic [SPEC_AW-1:0] s,
      logic [ROW_W-1:0] r, logic [COL_W-1:0] c, logic [15:0] e, logic [23:0] lg,
      logic inv, logic [17:0] u);
      logic [REQ_TDATA_W-1:0] w;
      w = '0;
      w[F_SPECIES_LO +: SPEC_AW] = s;
      w[F_ROW_LO +: ROW_W] = r;
      w[F_COL_LO +: COL_W] = c;
      w[F_ENTRY_LO +: 16] = e;
      w[F_LOG_LO +: 24] = lg;
      w[F_INVALID] = inv;
      w[F_U_LO +: 18] = u;
      return w;
   endfunction

   function automatic logic [15:0] pick_entry();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [23:0] pick_log();
      longint span, off, lg;
      if ($urandom_range(0, 3) == 0 || sb.grid_inv_step == 0) return 24'($urandom);
      span = ((longint'(TA_POINTS - 1) << 16) << 16) / longint'(sb.grid_inv_step);
      if (span > (longint'(1) << 25)) span = longint'(1) << 25;
      off = longint'($urandom_range(0, 32'(span + span / 4))) - span / 8;
      lg = longint'($signed(sb.grid_start)) + off;
      if (lg < -8388608) lg = -8388608;
      if (lg > 8388607) lg = 8388607;
      return 24'(lg);
   endfunction

   function automatic logic [17:0] pick_u();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return {1'b1, 17'($urandom)};
      if (r == 1) return 18'($urandom_range(65537, 131071));
      return 18'($urandom_range(0, 65536));
   endfunction

   task automatic send_word(bit kind, logic [REQ_TDATA_W-1:0] w);
      int idle;
      idle = (req_gaps_on && $urandom_range(0, 99) < 25) ? gap_cycles() : 0;
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(kind, w);
      words_sent++;
   endtask

   task automatic send_write(logic [SPEC_AW-1:0] s, int r, int c, logic [15:0] e);
      send_word(KIND_WRITE, pack_req(s, ROW_W'(r), COL_W'(c), e, 24'($urandom),
                                     1'($urandom), 18'($urandom)));
   endtask

   // Unwritten neighbors are written first, with fill or with random values when fill < 0.
   task automatic lookup(logic [SPEC_AW-1:0] s, logic [23:0] lg, logic inv, logic [17:0] u,
                         int fill);
      int i0, i1, j0, j1;
      longint fx, fy;
      int rows [4];
      int cols [4];
      sb.locate(lg, u, i0, i1, j0, j1, fx, fy);
      rows = '{i0, i1, i0, i1};
      cols = '{j0, j0, j1, j1};
      for (int k = 0; k < 4; k++) begin
         if (!sb.chi_written[sb.slot(s, rows[k], cols[k])])
            send_write(s, rows[k], cols[k], (fill < 0) ? pick_entry() : 16'(fill));
      end
      send_word(KIND_LOOKUP, pack_req(s, ROW_W'($urandom), COL_W'($urandom), 16'($urandom),
                                      lg, inv, u));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending_chi.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The caller drops csr_we once its last register is written.
   task automatic write_reg(logic idx, logic [23:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_GRID_START) sb.grid_start = val;
      else sb.grid_inv_step = val;
   endtask

   task automatic run_phase(int count);
      int target;
      target = words_sent + count;
      while (words_sent < target) begin
         if ($urandom_range(0, 99) < 20) begin
            send_write(2'($urandom), $urandom_range(0, TA_POINTS - 1),
                       $urandom_range(0, U_POINTS - 1), pick_entry());
         end else begin
            lookup(2'($urandom), pick_log(), $urandom_range(0, 19) == 0, pick_u(),
                   ($urandom_range(0, 9) == 0) ? int'(pick_entry()) : -1);
         end
         if ($urandom_range(0, 199) == 0) wait_drained();
      end
   endtask

   initial begin
      logic [23:0] start_set [6];
      logic [23:0] step_set [6];
      bit          gaps_set [6];
      bit          stalls_set [6];

      start_set = '{24'h800000, 24'h7FFFFF, 24'hF80000, 24'($urandom), 24'h000000, 24'hFF0000};
      step_set = '{24'h000000, 24'hFFFFFF, 24'h008000,
                   24'($urandom_range(4096, 1 << 20)), 24'h010000, 24'h000001};
      gaps_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
      stalls_set = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset grid: one row per unit of the logarithm.
      send_write(0, TA_POINTS - 1, U_POINTS - 1, 16'hFFFF);
      send_write(0, 0, 0, 16'h0000);
      lookup(0, 24'h800000, 1'b0, 18'h20000, 16'h8000);
      lookup(0, 24'h7FFFFF, 1'b0, 18'h1FFFF, -1);
      lookup(0, 24'h000000, 1'b1, 18'h00000, -1);
      lookup(3, 24'h058000, 1'b0, 18'h08000, 16'hFFFF);
      lookup(2, 24'h0A0000, 1'b0, 18'h10000, -1);
      lookup(2, 24'h0A0000, 1'b0, 18'h00000, -1);
      lookup(1, 24'h144000, 1'b0, 18'd31210, -1);
      send_write(1, 20, 30, 16'h1234);
      lookup(1, 24'h144000, 1'b0, 18'd31210, -1);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_GRID_START, start_set[p]);
         write_reg(CSR_GRID_INV_STEP, step_set[p]);
         csr_we <= 1'b0;
         req_gaps_on = gaps_set[p];
         rsp_stalls_on = stalls_set[p];
         run_phase(255);
         wait_drained();
      end

      if (sb.mismatches == 0 && sb.pending_chi.size() == 0) begin
         $display("table_bilinear_interp_lookup regression: pass");
      end else begin
         $display("table_bilinear_interp_lookup regression: fail");
      end
      $finish;
   end
endmodule
